[sv/ccs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccs_pkg: shared types and constants for the C comment stripper
// Scanner state encoding, character codes and the per-byte scan result.
// ----------------------------------------------------------------------------
package ccs_pkg;

   // scanner states; codes 5..7 never arise and act like normal
   typedef enum logic [2:0] {
      ST_NORMAL = 3'd0,
      ST_SLASH  = 3'd1,
      ST_BLOCK  = 3'd2,
      ST_STAR   = 3'd3,
      ST_LINE   = 3'd4
   } scan_state_type;

   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_CR      = 8'h0D;

   // what one input byte produces: up to two output bytes
   typedef struct packed {
      scan_state_type next_state;
      logic [1:0]     count;
      logic [7:0]     byte0;
      logic [7:0]     byte1;
   } scan_result_type;

endpackage

[sv/ccs_scan.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccs_scan: comment scanner logic
// Next-state and emitted bytes for one source byte, given the current state.
// ----------------------------------------------------------------------------
module ccs_scan (
   input  ccs_pkg::scan_state_type  state,
   input  logic [7:0]               in_byte,
   input  logic                     strip_ws,
   output ccs_pkg::scan_result_type result
);

   logic is_space;
   logic keep_byte;
   logic got_slash;
   logic is_star;
   logic is_newline;

   // whitespace classification
   assign is_space   = (in_byte == ccs_pkg::CH_SPACE) ||
                       ((in_byte >= ccs_pkg::CH_TAB) && (in_byte <= ccs_pkg::CH_CR));
   assign keep_byte  = !(strip_ws && is_space);
   assign got_slash  = (in_byte == ccs_pkg::CH_SLASH);
   assign is_star    = (in_byte == ccs_pkg::CH_STAR);
   assign is_newline = (in_byte == ccs_pkg::CH_NEWLINE);

   // next state
   always_comb begin
      result.next_state = ccs_pkg::ST_NORMAL;
      unique case (state)
         ccs_pkg::ST_SLASH: begin
            if (is_star)
               result.next_state = ccs_pkg::ST_BLOCK;
            else if (got_slash)
               result.next_state = ccs_pkg::ST_LINE;
            else
               result.next_state = ccs_pkg::ST_NORMAL;
         end
         ccs_pkg::ST_BLOCK: begin
            result.next_state = is_star ? ccs_pkg::ST_STAR : ccs_pkg::ST_BLOCK;
         end
         ccs_pkg::ST_STAR: begin
            if (got_slash)
               result.next_state = ccs_pkg::ST_NORMAL;
            else if (is_star)
               result.next_state = ccs_pkg::ST_STAR;
            else
               result.next_state = ccs_pkg::ST_BLOCK;
         end
         ccs_pkg::ST_LINE: begin
            result.next_state = is_newline ? ccs_pkg::ST_NORMAL : ccs_pkg::ST_LINE;
         end
         default: begin
            result.next_state = got_slash ? ccs_pkg::ST_SLASH : ccs_pkg::ST_NORMAL;
         end
      endcase
   end

   // emitted bytes
   always_comb begin
      result.count = 2'd0;
      result.byte0 = in_byte;
      result.byte1 = in_byte;
      unique case (state)
         ccs_pkg::ST_SLASH: begin
            // held slash did not open a comment: release it, then the byte if kept
            if (!is_star && !got_slash) begin
               result.byte0 = ccs_pkg::CH_SLASH;
               result.count = keep_byte ? 2'd2 : 2'd1;
            end
         end
         ccs_pkg::ST_BLOCK, ccs_pkg::ST_STAR: begin
            result.count = 2'd0;
         end
         ccs_pkg::ST_LINE: begin
            // newline ending a line comment survives unless stripping
            if (is_newline && !strip_ws)
               result.count = 2'd1;
         end
         default: begin
            if (!got_slash && keep_byte)
               result.count = 2'd1;
         end
      endcase
   end

endmodule

[sv/c_comment_stripper_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_comment_stripper_top: C comment removal on a byte stream
// Drops block and line comments, optionally whitespace, one byte per cycle unless the result buffer holds it off.
// ----------------------------------------------------------------------------
// Output: the first result of an accepted byte appears on rsp_ in the cycle after the byte is accepted.
// Throughput: one byte per cycle while the result side does not stall; a kept
//   byte that releases a held slash gives two results and holds off the next
//   byte while the two-entry result buffer drains.
// Reset: synchronous, active high; scanner returns to normal, whitespace
//   stripping off, result buffer empty.
module c_comment_stripper_top (
   input  logic       clock,
   input  logic       reset,
   // input channel
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   // result channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_run,
   // configuration
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);

   ccs_pkg::scan_state_type  state_ff, state_in;
   ccs_pkg::scan_result_type scan;
   logic                     strip_ff, strip_in;
   logic [1:0]               cnt_ff, cnt_in;
   logic [7:0]               slot0_ff, slot0_in;
   logic                     last0_ff, last0_in;
   logic [7:0]               slot1_ff, slot1_in;
   logic                     push;
   logic                     pop;

   // scanner
   ccs_scan u_scan (
      .state    (state_ff),
      .in_byte  (req_in_byte),
      .strip_ws (strip_ff),
      .result   (scan)
   );

   // handshakes: take a byte once the buffer will be empty
   assign rsp_valid = (cnt_ff != 2'd0);
   assign pop       = rsp_valid && !rsp_stall;
   assign req_stall = !((cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && !rsp_stall));
   assign push      = req_valid && !req_stall;

   assign rsp_out_byte    = slot0_ff;
   assign rsp_last_of_run = last0_ff;

   // configuration register
   assign strip_in = csr_wr_en ? csr_wr_data : strip_ff;

   // scanner state advances once per accepted transaction
   assign state_in = push ? scan.next_state : state_ff;

   // result buffer: head slot plus one pending slot (always the last)
   always_comb begin
      cnt_in   = cnt_ff;
      slot0_in = slot0_ff;
      last0_in = last0_ff;
      slot1_in = slot1_ff;
      if (push) begin
         cnt_in   = scan.count;
         slot0_in = scan.byte0;
         last0_in = (scan.count == 2'd1);
         slot1_in = scan.byte1;
      end else if (pop) begin
         cnt_in   = cnt_ff - 2'd1;
         slot0_in = slot1_ff;
         last0_in = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ccs_pkg::ST_NORMAL;
         strip_ff <= 1'b0;
         cnt_ff   <= 2'd0;
      end else begin
         state_ff <= state_in;
         strip_ff <= strip_in;
         cnt_ff   <= cnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      last0_ff <= last0_in;
      slot1_ff <= slot1_in;
   end

endmodule

[sv/ccs_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccs_checker: port-level checks for the C comment stripper
// Result buffer ordering and input flow control, bound to the top level.
// ----------------------------------------------------------------------------
module ccs_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last_of_run
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte) &&
                                 $stable(rsp_last_of_run))
      else $error("result changed while stalled");

   // with nothing pending the block takes input
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty result buffer");

   // a first-of-two result is followed at once by the final one
   a_pair_next: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_of_run |=> rsp_valid && rsp_last_of_run)
      else $error("second result of a pair missing");

   // while a pair is pending no new input is taken
   a_pair_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_run |-> req_stall)
      else $error("input accepted while a result pair is pending");

endmodule

bind c_comment_stripper_top ccs_checker u_ccs_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_out_byte    (rsp_out_byte),
   .rsp_last_of_run (rsp_last_of_run)
);

[tb/ccs_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccs_scoreboard: scoreboard for the C comment stripper
// Watches the byte and result channels, runs its own scanner copy on every
// accepted byte and compares each accepted result with the oldest expected one.
// ----------------------------------------------------------------------------
module ccs_scoreboard (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_out_byte,
   input  logic       rsp_last_of_run,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   output int         mismatch_count,
   output int         pending_count,
   output int         result_count
);

   localparam int MAX_PRINTED = 30;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } kept_byte_type;

   kept_byte_type           kept_q[$];
   ccs_pkg::scan_state_type scan_st  = ccs_pkg::ST_NORMAL;
   logic                    strip_ws = 1'b0;
   int                      errors   = 0;
   int                      results  = 0;

   // whitespace in the C locale: space and 0x09..0x0D
   function automatic logic is_blank(input logic [7:0] b);
      return (b == ccs_pkg::CH_SPACE) || (b >= ccs_pkg::CH_TAB && b <= ccs_pkg::CH_CR);
   endfunction

   // next scanner state and the bytes that one source byte lets through
   function automatic ccs_pkg::scan_result_type predict_scan(
         input ccs_pkg::scan_state_type st,
         input logic strip,
         input logic [7:0] b);
      ccs_pkg::scan_result_type r;
      r.next_state = st;
      r.count      = 2'd0;
      r.byte0      = 8'h00;
      r.byte1      = 8'h00;
      unique case (st)
         ccs_pkg::ST_SLASH: begin
            if (b == ccs_pkg::CH_STAR) begin
               r.next_state = ccs_pkg::ST_BLOCK;
            end else if (b == ccs_pkg::CH_SLASH) begin
               r.next_state = ccs_pkg::ST_LINE;
            end else begin
               // held slash did not open a comment: release it
               r.byte0 = ccs_pkg::CH_SLASH;
               r.count = 2'd1;
               if (!(strip && is_blank(b))) begin
                  r.byte1 = b;
                  r.count = 2'd2;
               end
               r.next_state = ccs_pkg::ST_NORMAL;
            end
         end
         ccs_pkg::ST_BLOCK: begin
            if (b == ccs_pkg::CH_STAR) r.next_state = ccs_pkg::ST_STAR;
         end
         ccs_pkg::ST_STAR: begin
            if (b == ccs_pkg::CH_SLASH) r.next_state = ccs_pkg::ST_NORMAL;
            else if (b != ccs_pkg::CH_STAR) r.next_state = ccs_pkg::ST_BLOCK;
         end
         ccs_pkg::ST_LINE: begin
            if (b == ccs_pkg::CH_NEWLINE) begin
               if (!strip) begin
                  r.byte0 = b;
                  r.count = 2'd1;
               end
               r.next_state = ccs_pkg::ST_NORMAL;
            end
         end
         default: begin
            if (b == ccs_pkg::CH_SLASH) begin
               r.next_state = ccs_pkg::ST_SLASH;
            end else begin
               if (!(strip && is_blank(b))) begin
                  r.byte0 = b;
                  r.count = 2'd1;
               end
               r.next_state = ccs_pkg::ST_NORMAL;
            end
         end
      endcase
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      if (errors < MAX_PRINTED)
         $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
   endtask

   // predict on accepted bytes, compare on accepted results
   always @(posedge clock) begin : monitor
      ccs_pkg::scan_result_type step;
      kept_byte_type            entry;
      if (reset) begin
         scan_st  = ccs_pkg::ST_NORMAL;
         strip_ws = 1'b0;
         kept_q.delete();
      end else begin
         if (csr_wr_en) strip_ws = csr_wr_data;
         if (req_valid && !req_stall) begin
            step    = predict_scan(scan_st, strip_ws, req_in_byte);
            scan_st = step.next_state;
            if (step.count != 2'd0) begin
               entry.data = step.byte0;
               entry.last = (step.count == 2'd1);
               kept_q.push_back(entry);
            end
            if (step.count == 2'd2) begin
               entry.data = step.byte1;
               entry.last = 1'b1;
               kept_q.push_back(entry);
            end
         end
         if (rsp_valid && !rsp_stall) begin
            results++;
            if (kept_q.size() == 0) begin
               report_mismatch($sformatf("unexpected result byte %02h", rsp_out_byte));
            end else begin
               entry = kept_q.pop_front();
               if (rsp_out_byte !== entry.data)
                  report_mismatch($sformatf("out_byte %02h, expected %02h",
                                            rsp_out_byte, entry.data));
               if (rsp_last_of_run !== entry.last)
                  report_mismatch($sformatf("last_of_run %b, expected %b (byte %02h)",
                                            rsp_last_of_run, entry.last, entry.data));
            end
         end
      end
      pending_count  <= kept_q.size();
      mismatch_count <= errors;
      result_count   <= results;
   end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench top for the C comment stripper
// Feeds directed byte strings and then random C-like text (comments, division,
// whitespace, noise) under both whitespace settings with random stalls on both
// channels; the scoreboard module scores every result.
// ----------------------------------------------------------------------------
module tb;

   localparam int LIMIT_CYCLES     = 400000;
   localparam int PHASES           = 6;
   localparam int PHASE_BYTES      = 200;
   localparam int LONG_HOLD_CYCLES = 250;
   localparam int SETTLE_CYCLES    = 4;

   localparam logic [7:0] CH_VTAB     = 8'h0B;
   localparam logic [7:0] CH_FORMFEED = 8'h0C;

   logic       clock           = 1'b0;
   logic       reset           = 1'b1;
   logic       req_valid       = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte     = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall       = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_last_of_run;
   logic       csr_wr_en       = 1'b0;
   logic       csr_wr_data     = 1'b0;

   int mismatch_count;
   int pending_count;
   int result_count;

   logic [7:0] text_q[$];
   int         bytes_sent   = 0;
   int         cycle_count  = 0;
   logic       send_idling  = 1'b1;
   logic       rsp_idling   = 1'b1;
   logic       long_hold    = 1'b0;

   c_comment_stripper_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   ccs_scoreboard scoreboard (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .mismatch_count  (mismatch_count),
      .pending_count   (pending_count),
      .result_count    (result_count)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // result side: random stall bursts, plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            long_hold = 1'b0;
            rsp_stall <= 1'b0;
         end else if (rsp_idling && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 18)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic logic [7:0] any_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   // offer every queued byte, one transaction each, with random gaps while send_idling is set
   task automatic send_text();
      logic [7:0] b;
      while (text_q.size() != 0) begin
         b = text_q.pop_front();
         req_valid   <= 1'b1;
         req_in_byte <= b;
         @(posedge clock);
         while (req_stall) @(posedge clock);
         bytes_sent++;
         if (send_idling && $urandom_range(0, 9) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end
      end
   endtask

   // stop offering until every expected result is back, then let it settle
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_strip(input logic value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // one random piece of C-like text; some pieces are left unterminated
   task automatic build_fragment();
      int         kind;
      logic [7:0] b;
      kind = $urandom_range(0, 9);
      if (kind <= 2) begin
         // block comment with stars and slashes inside
         text_q.push_back(ccs_pkg::CH_SLASH);
         text_q.push_back(ccs_pkg::CH_STAR);
         repeat ($urandom_range(0, 8)) begin
            case ($urandom_range(0, 3))
               0:       text_q.push_back(ccs_pkg::CH_STAR);
               1:       text_q.push_back(ccs_pkg::CH_SLASH);
               default: text_q.push_back(any_byte());
            endcase
         end
         if ($urandom_range(0, 7) != 0) begin
            repeat ($urandom_range(1, 3)) text_q.push_back(ccs_pkg::CH_STAR);
            text_q.push_back(ccs_pkg::CH_SLASH);
         end
      end else if (kind <= 4) begin
         // line comment
         text_q.push_back(ccs_pkg::CH_SLASH);
         text_q.push_back(ccs_pkg::CH_SLASH);
         repeat ($urandom_range(0, 8)) begin
            b = any_byte();
            if (b == ccs_pkg::CH_NEWLINE) b = ccs_pkg::CH_SPACE;
            text_q.push_back(b);
         end
         if ($urandom_range(0, 7) != 0) text_q.push_back(ccs_pkg::CH_NEWLINE);
      end else if (kind == 5) begin
         // slash that is only division
         text_q.push_back(ccs_pkg::CH_SLASH);
         b = any_byte();
         if (b == ccs_pkg::CH_SLASH || b == ccs_pkg::CH_STAR) b = ccs_pkg::CH_SPACE;
         text_q.push_back(b);
      end else if (kind <= 7) begin
         repeat ($urandom_range(1, 6)) text_q.push_back(any_byte());
      end else if (kind == 8) begin
         // whitespace run, with the two neighbors of the 0x09..0x0D range
         repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(0, 7))
               0:       text_q.push_back(ccs_pkg::CH_SPACE);
               1:       text_q.push_back(ccs_pkg::CH_TAB);
               2:       text_q.push_back(CH_VTAB);
               3:       text_q.push_back(CH_FORMFEED);
               4:       text_q.push_back(ccs_pkg::CH_CR);
               5:       text_q.push_back(ccs_pkg::CH_NEWLINE);
               6:       text_q.push_back(ccs_pkg::CH_TAB - 8'd1);
               default: text_q.push_back(ccs_pkg::CH_CR + 8'd1);
            endcase
         end
      end else begin
         // noise made of the bytes the scanner reacts to
         repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(0, 3))
               0:       text_q.push_back(ccs_pkg::CH_SLASH);
               1:       text_q.push_back(ccs_pkg::CH_STAR);
               2:       text_q.push_back(ccs_pkg::CH_NEWLINE);
               default: text_q.push_back(any_byte());
            endcase
         end
      end
   endtask

   // stimulus and verdict
   initial begin : stimulus
      int phase_start;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      set_strip(1'b0);

      // directed, whitespace kept: byte extremes, division, a block comment
      // with stars in a row, a line comment, slash before space, then a
      // trailing slash left held across the register write
      text_q = '{8'h00, 8'hFF, ccs_pkg::CH_SLASH, 8'h62,
                 ccs_pkg::CH_SLASH, ccs_pkg::CH_STAR, ccs_pkg::CH_STAR,
                 ccs_pkg::CH_STAR, ccs_pkg::CH_SLASH,
                 ccs_pkg::CH_SLASH, ccs_pkg::CH_SLASH, 8'h71, ccs_pkg::CH_NEWLINE,
                 ccs_pkg::CH_SLASH, ccs_pkg::CH_SPACE, ccs_pkg::CH_SLASH};
      send_text();
      set_strip(1'b1);

      // directed, whitespace dropped: held slash before a space, every
      // blank byte, and a line comment whose newline is dropped
      text_q = '{ccs_pkg::CH_SPACE, ccs_pkg::CH_TAB, CH_VTAB, CH_FORMFEED,
                 ccs_pkg::CH_CR, ccs_pkg::CH_NEWLINE,
                 ccs_pkg::CH_SLASH, ccs_pkg::CH_SLASH, ccs_pkg::CH_NEWLINE};
      send_text();

      // random phases; the last one runs with no idling at all
      for (int p = 0; p < PHASES; p++) begin
         set_strip((p % 2) == 1);
         send_idling = (p == 0 || p == 1 || p == 3);
         rsp_idling  = (p == 0 || p == 1 || p == 4);
         if (p == 1) long_hold = 1'b1;
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < PHASE_BYTES) begin
            build_fragment();
            send_text();
         end
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d source bytes (directed strings, then random C-like text)", bytes_sent);
      $display("Checked %0d results with whitespace stripping off and on", result_count);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
